@@ src/dsa_pkg.sv @@
// Package: shared types, constants and lane gating for the depop accumulator.
`timescale 1ns / 1ps

package dsa_pkg;

  localparam int NUM_STUDIOS  = 8;
  localparam int STUDIO_W     = 3;
  localparam int NUM_LANES    = 9;
  localparam int DELTA_W      = 16;
  localparam int SUM_W        = 24;
  localparam int MC_W         = 16;
  localparam int STUDIO_DEPTH = (NUM_STUDIOS < (1 << STUDIO_W)) ? NUM_STUDIOS : (1 << STUDIO_W);
  localparam int IDX_W        = (STUDIO_DEPTH > 1) ? $clog2(STUDIO_DEPTH) : 1;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7fffff;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -24'sh7fffff;

  localparam logic [MC_W-1:0] MC_MAIN_SURR = 16'h0004;
  localparam logic [MC_W-1:0] MC_AUX_A     = 16'h0001;
  localparam logic [MC_W-1:0] MC_AUX_A_SUR = 16'h0014;
  localparam logic [MC_W-1:0] MC_AUX_B     = 16'h0012;
  localparam logic [MC_W-1:0] MC_AUX_B_SUR = 16'h0004;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [DELTA_W-1:0] delta_t;

  typedef struct packed {
    logic             we;
    logic             clr;
    logic             add;
    logic [IDX_W-1:0] idx;
  } lane_ctrl_t;

  typedef struct packed {
    logic [STUDIO_W-1:0]       studio;
    logic [NUM_LANES-1:0][SUM_W-1:0] sums;
  } res_t;

  function automatic logic [NUM_LANES-1:0] lane_enable(input logic [MC_W-1:0] mc);
    logic aux_a;
    logic aux_b;
    logic [NUM_LANES-1:0] en;
    aux_a = (mc & MC_AUX_A) != '0;
    aux_b = (mc & MC_AUX_B) != '0;
    en[0] = 1'b1;
    en[1] = 1'b1;
    en[2] = (mc & MC_MAIN_SURR) != '0;
    en[3] = aux_a;
    en[4] = aux_a;
    en[5] = aux_a && ((mc & MC_AUX_A_SUR) != '0);
    en[6] = aux_b;
    en[7] = aux_b;
    en[8] = aux_b && ((mc & MC_AUX_B_SUR) != '0);
    return en;
  endfunction

endpackage

@@ src/depop_saturating_accumulator.sv @@
// Top level: depop saturating accumulator with nine parallel lanes.
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per voice-stop
//   or clear event: mode, studio, mixer control and nine 16-bit deltas.
//   Output channel (out_valid_o / out_ready_i) returns one beat per input
//   beat: the studio index and its nine 24-bit sums after the update.
//   Nine lanes, one per sum, each hold that sum for every studio and do a
//   read, saturating add or clear, and write-back in the accept cycle; the result is
//   merged into the output buffer.
//   Throughput: 1 beat per cycle while the output buffer has room.
//   A two-entry output buffer keeps intake running while a result waits;
//   when both entries hold results, in_ready_o drops until the
//   receiver takes a beat.
//   Reset clears all sums to zero and empties the output buffer; no
//   clearing pass is needed, the block accepts beats right after reset.
//   A studio index beyond the studio count changes nothing and reports
//   zero sums.
`timescale 1ns / 1ps

module depop_saturating_accumulator import dsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [STUDIO_W-1:0] studio_i,
  input  logic [MC_W-1:0]     mixer_control_i,
  input  delta_t              delta_left_i,
  input  delta_t              delta_right_i,
  input  delta_t              delta_surround_i,
  input  delta_t              delta_aux_a_left_i,
  input  delta_t              delta_aux_a_right_i,
  input  delta_t              delta_aux_a_surround_i,
  input  delta_t              delta_aux_b_left_i,
  input  delta_t              delta_aux_b_right_i,
  input  delta_t              delta_aux_b_surround_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STUDIO_W-1:0] studio_out_o,
  output sum_t                sum_left_o,
  output sum_t                sum_right_o,
  output sum_t                sum_surround_o,
  output sum_t                sum_aux_a_left_o,
  output sum_t                sum_aux_a_right_o,
  output sum_t                sum_aux_a_surround_o,
  output sum_t                sum_aux_b_left_o,
  output sum_t                sum_aux_b_right_o,
  output sum_t                sum_aux_b_surround_o
);

  logic                 accept;
  logic                 in_range;
  logic [NUM_LANES-1:0] lane_en;
  delta_t               deltas [NUM_LANES];
  sum_t                 lane_sum [NUM_LANES];
  lane_ctrl_t           lane_ctrl [NUM_LANES];
  res_t                 res_d;
  res_t                 res_o;

  assign accept   = in_valid_i && in_ready_o;
  assign in_range = {1'b0, studio_i} < (STUDIO_W + 1)'(NUM_STUDIOS);
  assign lane_en  = lane_enable(mixer_control_i);

  assign deltas[0] = delta_left_i;
  assign deltas[1] = delta_right_i;
  assign deltas[2] = delta_surround_i;
  assign deltas[3] = delta_aux_a_left_i;
  assign deltas[4] = delta_aux_a_right_i;
  assign deltas[5] = delta_aux_a_surround_i;
  assign deltas[6] = delta_aux_b_left_i;
  assign deltas[7] = delta_aux_b_right_i;
  assign deltas[8] = delta_aux_b_surround_i;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign lane_ctrl[g].we  = accept && in_range;
    assign lane_ctrl[g].clr = mode_i == MODE_CLEAR;
    assign lane_ctrl[g].add = (mode_i == MODE_ADD) && lane_en[g];
    assign lane_ctrl[g].idx = IDX_W'(studio_i);

    dsa_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl[g]),
      .delta_i (deltas[g]),
      .sum_o   (lane_sum[g])
    );

    assign res_d.sums[g] = in_range ? lane_sum[g] : '0;
  end

  assign res_d.studio = studio_i;

  dsa_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res_d),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_o)
  );

  assign studio_out_o         = res_o.studio;
  assign sum_left_o           = res_o.sums[0];
  assign sum_right_o          = res_o.sums[1];
  assign sum_surround_o       = res_o.sums[2];
  assign sum_aux_a_left_o     = res_o.sums[3];
  assign sum_aux_a_right_o    = res_o.sums[4];
  assign sum_aux_a_surround_o = res_o.sums[5];
  assign sum_aux_b_left_o     = res_o.sums[6];
  assign sum_aux_b_right_o    = res_o.sums[7];
  assign sum_aux_b_surround_o = res_o.sums[8];

  a_accept_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no output");

endmodule

@@ src/dsa_lane.sv @@
// One accumulator lane: per-studio saturating sum with clear.
`timescale 1ns / 1ps

module dsa_lane import dsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lane_ctrl_t ctrl_i,
  input  delta_t     delta_i,
  output sum_t       sum_o
);

  sum_t                    sums_q [STUDIO_DEPTH];
  sum_t                    rd_sum;
  logic signed [SUM_W:0]   raw;
  sum_t                    sat_sum;
  sum_t                    sum_d;

  assign rd_sum = sums_q[ctrl_i.idx];
  assign raw    = {rd_sum[SUM_W-1], rd_sum}
                + {{(SUM_W + 1 - DELTA_W){delta_i[DELTA_W-1]}}, delta_i};

  always_comb begin
    if (raw > $signed({SUM_MAX[SUM_W-1], SUM_MAX})) begin
      sat_sum = SUM_MAX;
    end else if (raw < $signed({SUM_MIN[SUM_W-1], SUM_MIN})) begin
      sat_sum = SUM_MIN;
    end else begin
      sat_sum = raw[SUM_W-1:0];
    end
  end

  always_comb begin
    if (ctrl_i.clr) begin
      sum_d = '0;
    end else if (ctrl_i.add) begin
      sum_d = sat_sum;
    end else begin
      sum_d = rd_sum;
    end
  end

  assign sum_o = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STUDIO_DEPTH; i++) begin
        sums_q[i] <= '0;
      end
    end else if (ctrl_i.we) begin
      sums_q[ctrl_i.idx] <= sum_d;
    end
  end

  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.we |-> sum_d != {1'b1, {(SUM_W-1){1'b0}}})
    else $error("lane sum reached the negative full-scale code");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.we && ctrl_i.clr) |=> sums_q[$past(ctrl_i.idx)] == '0)
    else $error("cleared studio sum is not zero");

endmodule

@@ src/dsa_out_buf.sv @@
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps

module dsa_out_buf import dsa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic ready_i,
  output res_t data_o
);

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;
  logic out_fire;

  assign out_fire = out_valid_q && ready_i;
  assign ready_o  = !skid_valid_q;
  assign valid_o  = out_valid_q;
  assign data_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_fire) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid beat held while output register empty");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("beat pushed into full result buffer");

endmodule
